### sv/csfd_pkg.sv
// Shared types, constants and the bytewise CRC-32 step for the frame deframer.
`default_nettype none

package csfd_pkg;

  localparam logic [7:0]  SYNC_FIRST  = 8'h55;
  localparam logic [7:0]  SYNC_SECOND = 8'hAA;
  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC_PRESET  = 32'hFFFFFFFF;

  localparam int unsigned IDX_W      = 10;
  localparam int unsigned LEN_OUT_W  = 10;
  localparam int unsigned FIFO_DEPTH = 4;

  // Result kinds as seen on the output port.
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2
  } kind_e;

  // What the back end has to do with a queued byte.
  typedef enum logic [2:0] {
    CLS_START,
    CLS_HDR,
    CLS_DATA,
    CLS_CRC,
    CLS_LAST
  } cls_e;

  // Parser states of the front end.
  typedef enum logic [3:0] {
    ST_HUNT,
    ST_SYNC2,
    ST_CMD,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_SEQ_LO,
    ST_SEQ_HI,
    ST_PAYLOAD,
    ST_CRC
  } state_e;

  typedef struct packed {
    cls_e                   cls;
    logic [7:0]             data;
    logic [IDX_W-1:0]       idx;
    logic [7:0]             cmd;
    logic [LEN_OUT_W-1:0]   len;
  } entry_t;

  // Reflected CRC-32, one byte folded in, no final inversion.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/csfd_front.sv
// Front end: frame parser that classifies each received byte and queues work.
`default_nettype none

module csfd_front #(
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             acc_i,
  input  wire logic [7:0]       rx_byte_i,
  output logic                  push_o,
  output csfd_pkg::entry_t      entry_o
);

  localparam int unsigned CNT_W     = $clog2(MAX_PAYLOAD + 2);
  localparam logic [15:0] LEN_LIMIT = 16'(MAX_PAYLOAD + 1);

  csfd_pkg::state_e state_q, state_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [15:0]      len_q, len_d;
  logic [CNT_W-1:0] pay_cnt_q, pay_cnt_d;
  logic [1:0]       crc_cnt_q, crc_cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= csfd_pkg::ST_HUNT;
      cmd_q     <= '0;
      len_q     <= '0;
      pay_cnt_q <= '0;
      crc_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      cmd_q     <= cmd_d;
      len_q     <= len_d;
      pay_cnt_q <= pay_cnt_d;
      crc_cnt_q <= crc_cnt_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    len_d         = len_q;
    pay_cnt_d     = pay_cnt_q;
    crc_cnt_d     = crc_cnt_q;
    push_o        = 1'b0;
    entry_o.cls   = csfd_pkg::CLS_HDR;
    entry_o.data  = rx_byte_i;
    entry_o.idx   = csfd_pkg::IDX_W'(pay_cnt_q);
    entry_o.cmd   = cmd_q;
    entry_o.len   = csfd_pkg::LEN_OUT_W'(len_q);
    if (acc_i) begin
      unique case (state_q)
        csfd_pkg::ST_HUNT: begin
          if (rx_byte_i == csfd_pkg::SYNC_FIRST) state_d = csfd_pkg::ST_SYNC2;
        end
        csfd_pkg::ST_SYNC2: begin
          // A wrong second sync byte is not rechecked as a first sync byte.
          if (rx_byte_i == csfd_pkg::SYNC_SECOND) begin
            state_d     = csfd_pkg::ST_CMD;
            push_o      = 1'b1;
            entry_o.cls = csfd_pkg::CLS_START;
          end else begin
            state_d = csfd_pkg::ST_HUNT;
          end
        end
        csfd_pkg::ST_CMD: begin
          cmd_d   = rx_byte_i;
          push_o  = 1'b1;
          state_d = csfd_pkg::ST_LEN_LO;
        end
        csfd_pkg::ST_LEN_LO: begin
          len_d   = {len_q[15:8], rx_byte_i};
          push_o  = 1'b1;
          state_d = csfd_pkg::ST_LEN_HI;
        end
        csfd_pkg::ST_LEN_HI: begin
          len_d   = {rx_byte_i, len_q[7:0]};
          push_o  = 1'b1;
          state_d = csfd_pkg::ST_SEQ_LO;
        end
        csfd_pkg::ST_SEQ_LO: begin
          push_o  = 1'b1;
          state_d = csfd_pkg::ST_SEQ_HI;
        end
        csfd_pkg::ST_SEQ_HI: begin
          push_o    = 1'b1;
          pay_cnt_d = '0;
          crc_cnt_d = '0;
          if (len_q > LEN_LIMIT) begin
            state_d = csfd_pkg::ST_HUNT;
          end else if (len_q == 16'd0) begin
            state_d = csfd_pkg::ST_CRC;
          end else begin
            state_d = csfd_pkg::ST_PAYLOAD;
          end
        end
        csfd_pkg::ST_PAYLOAD: begin
          push_o      = 1'b1;
          entry_o.cls = csfd_pkg::CLS_DATA;
          pay_cnt_d   = pay_cnt_q + 1'b1;
          if (16'(pay_cnt_q) + 16'd1 == len_q) state_d = csfd_pkg::ST_CRC;
        end
        csfd_pkg::ST_CRC: begin
          push_o    = 1'b1;
          crc_cnt_d = crc_cnt_q + 1'b1;
          if (crc_cnt_q == 2'd3) begin
            entry_o.cls = csfd_pkg::CLS_LAST;
            state_d     = csfd_pkg::ST_HUNT;
          end else begin
            entry_o.cls = csfd_pkg::CLS_CRC;
          end
        end
        default: state_d = csfd_pkg::ST_HUNT;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/csfd_fifo.sv
// Short work queue between the parser and the CRC/result back end.
`default_nettype none

module csfd_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire csfd_pkg::entry_t  push_data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output csfd_pkg::entry_t       pop_data_o
);

  localparam int unsigned PTR_W = $clog2(csfd_pkg::FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(csfd_pkg::FIFO_DEPTH + 1);

  csfd_pkg::entry_t  slot_q [csfd_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q, count_d;

  assign full_o     = (count_q == CNT_W'(csfd_pkg::FIFO_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    else if (!push_i && pop_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

### sv/csfd_back.sv
// Back end: runs the CRC, gathers the received CRC and drives the result register.
`default_nettype none

module csfd_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          empty_i,
  input  wire csfd_pkg::entry_t              entry_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         kind_o,
  output logic [7:0]                         command_o,
  output logic [7:0]                         data_byte_o,
  output logic [csfd_pkg::IDX_W-1:0]         byte_index_o,
  output logic [csfd_pkg::LEN_OUT_W-1:0]     payload_length_o
);

  logic [31:0] crc_q, crc_d;
  logic [31:0] rx_crc_q, rx_crc_d;
  logic        ov_q, ov_d;
  logic        load;
  logic [31:0] rx_full;
  logic [1:0]                      kind_q, kind_d;
  logic [7:0]                      cmd_q, cmd_d;
  logic [7:0]                      data_q, data_d;
  logic [csfd_pkg::IDX_W-1:0]      idx_q, idx_d;
  logic [csfd_pkg::LEN_OUT_W-1:0]  len_q, len_d;

  assign pop_o   = !empty_i && (!ov_q || out_ready_i);
  assign rx_full = {entry_i.data, rx_crc_q[31:8]};

  always_comb begin
    crc_d    = crc_q;
    rx_crc_d = rx_crc_q;
    load     = 1'b0;
    kind_d   = kind_q;
    cmd_d    = entry_i.cmd;
    data_d   = entry_i.data;
    idx_d    = entry_i.idx;
    len_d    = entry_i.len;
    if (pop_o) begin
      unique case (entry_i.cls)
        csfd_pkg::CLS_START: begin
          crc_d    = csfd_pkg::CRC_PRESET;
          rx_crc_d = '0;
        end
        csfd_pkg::CLS_HDR: begin
          crc_d = csfd_pkg::crc_byte(crc_q, entry_i.data);
        end
        csfd_pkg::CLS_DATA: begin
          crc_d  = csfd_pkg::crc_byte(crc_q, entry_i.data);
          load   = 1'b1;
          kind_d = csfd_pkg::KIND_DATA;
        end
        csfd_pkg::CLS_CRC: begin
          rx_crc_d = rx_full;
        end
        csfd_pkg::CLS_LAST: begin
          rx_crc_d = rx_full;
          load     = 1'b1;
          kind_d   = ((~crc_q) == rx_full) ? csfd_pkg::KIND_GOOD : csfd_pkg::KIND_BAD;
          data_d   = '0;
          idx_d    = '0;
        end
        default: ;
      endcase
    end
    ov_d = (ov_q && !out_ready_i) || load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q    <= csfd_pkg::CRC_PRESET;
      rx_crc_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      crc_q    <= crc_d;
      rx_crc_q <= rx_crc_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      cmd_q  <= cmd_d;
      data_q <= data_d;
      idx_q  <= idx_d;
      len_q  <= len_d;
    end
  end

  assign out_valid_o      = ov_q;
  assign kind_o           = kind_q;
  assign command_o        = cmd_q;
  assign data_byte_o      = data_q;
  assign byte_index_o     = idx_q;
  assign payload_length_o = len_q;

endmodule

`default_nettype wire

### sv/crc32_sync_frame_deframer.sv
// Top level of the sync-word framed receiver with CRC-32 verdict.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+------------------------------------------
//   in      | input     | in_valid_i/in_ready_o  | rx_byte_i
//   out     | output    | out_valid_o/out_ready_i| kind_o, command_o, data_byte_o,
//           |           |                        | byte_index_o, payload_length_o
//
// One byte transaction is taken per cycle while the queue is not full. A byte that yields a
// result goes through the queue: the parser writes it there at the accept edge, and the back
// end pops it once the output register is free or taken, folds it into the CRC and loads the
// output register. The input stalls only when the four-entry queue is full, which happens
// only while the output is held off; the output register refills in the cycle it is taken.
// Reset returns the parser to hunting for the first sync byte and presets the CRC.
`default_nettype none

module crc32_sync_frame_deframer #(
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [7:0]                        rx_byte_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [1:0]                             kind_o,
  output logic [7:0]                             command_o,
  output logic [7:0]                             data_byte_o,
  output logic [csfd_pkg::IDX_W-1:0]             byte_index_o,
  output logic [csfd_pkg::LEN_OUT_W-1:0]         payload_length_o
);

  // The front end classifies bytes as sync, header, payload or CRC; only bytes that
  // matter to the back end are pushed into the queue.
  logic             in_acc;
  logic             push;
  logic             full;
  logic             pop;
  logic             empty;
  csfd_pkg::entry_t push_entry;
  csfd_pkg::entry_t head_entry;

  assign in_ready_o = !full;
  assign in_acc     = in_valid_i && in_ready_o;

  csfd_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (in_acc),
    .rx_byte_i(rx_byte_i),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  csfd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_entry),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_data_o (head_entry)
  );

  // The back end keeps the running CRC and the gathered CRC word, and owns the
  // output register, so a waiting result never blocks the parser directly.
  csfd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .entry_i         (head_entry),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .command_o       (command_o),
    .data_byte_o     (data_byte_o),
    .byte_index_o    (byte_index_o),
    .payload_length_o(payload_length_o)
  );

endmodule

`default_nettype wire

### sv/csfd_checker.sv
// Port-level checks for the frame deframer and the bind that attaches them.
`default_nettype none

module csfd_checker #(
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic [7:0]                    rx_byte_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [1:0]                    kind_o,
  input wire logic [7:0]                    command_o,
  input wire logic [7:0]                    data_byte_o,
  input wire logic [csfd_pkg::IDX_W-1:0]    byte_index_o,
  input wire logic [csfd_pkg::LEN_OUT_W-1:0] payload_length_o
);

  localparam bit LEN_FITS = (MAX_PAYLOAD + 1) < (1 << csfd_pkg::LEN_OUT_W);

  // A stalled input transaction keeps its valid and its byte.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(rx_byte_i))
    else $error("input changed while stalled");

  // A stalled result keeps its valid and its whole payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(command_o)
      && $stable(data_byte_o) && $stable(byte_index_o) && $stable(payload_length_o))
    else $error("result changed while stalled");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o == csfd_pkg::KIND_DATA) || (kind_o == csfd_pkg::KIND_GOOD)
      || (kind_o == csfd_pkg::KIND_BAD))
    else $error("undefined result kind");

  a_verdict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != csfd_pkg::KIND_DATA) |-> (data_byte_o == 8'd0)
      && (byte_index_o == '0))
    else $error("verdict carries payload fields");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == csfd_pkg::KIND_DATA) |-> !LEN_FITS
      || (byte_index_o < payload_length_o))
    else $error("payload index beyond declared length");

endmodule

bind crc32_sync_frame_deframer csfd_checker #(
  .MAX_PAYLOAD(MAX_PAYLOAD)
) u_csfd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .rx_byte_i       (rx_byte_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .kind_o          (kind_o),
  .command_o       (command_o),
  .data_byte_o     (data_byte_o),
  .byte_index_o    (byte_index_o),
  .payload_length_o(payload_length_o)
);

`default_nettype wire
